@@ hw/rtl/bmh_pkg.sv @@
package bmh_pkg;

	// Heap geometry
	localparam int HEAP_DEPTH = 1024;
	localparam int ADDR_W     = $clog2(HEAP_DEPTH);
	localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
	localparam int KEY_W      = 32;
	localparam int STAT_W     = 2;

	// Stream packing: tdata = {pad, status, count, min_key}
	localparam int IN_DATA_W  = KEY_W;
	localparam int OUT_BITS   = KEY_W + CNT_W + STAT_W;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

	// Operation codes (tuser on the input side)
	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_DELETE = 1'b1;

	// Result status codes
	localparam logic [STAT_W-1:0] STAT_OK         = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL       = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY      = 2'd2;

endpackage

@@ hw/rtl/binary_min_heap.sv @@
// Binary min-heap of signed 32-bit keys, one result item per input item.
// Insert sifts the new key up from the next free leaf; delete sifts the last entry down from
// the root; each level moved (0..9) takes a read and a compare state. A rejected item goes
// straight to the result state; a waiting result holds the item there until it is taken.
// One item in work: the next accept can come in the cycle after the result loads.
// Reset (arst_n low, asynchronous) empties the heap; RAM contents are not cleared.
module binary_min_heap (
	input  logic                           clk,
	input  logic                           arst_n,
	// input item
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [bmh_pkg::IN_DATA_W-1:0]  s_tdata,   // [31:0] key
	input  logic                           s_tuser,   // [0] mode
	// result item
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [bmh_pkg::OUT_DATA_W-1:0] m_tdata    // [31:0] min_key, [42:32] count,
	                                                  // [44:43] status, rest zero
);

	localparam int AW = bmh_pkg::ADDR_W;
	localparam int CW = bmh_pkg::CNT_W;
	localparam int KW = bmh_pkg::KEY_W;
	localparam int XW = bmh_pkg::ADDR_W + 2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DEL_LOAD,
		ST_DN_RD,
		ST_DN_CMP,
		ST_UP_RD,
		ST_UP_CMP,
		ST_OUT
	} state_t;

	state_t                    state_q;
	logic [CW-1:0]             cnt_q;
	logic [AW-1:0]             pos_q;
	logic signed [KW-1:0]      key_q;
	logic signed [KW-1:0]      root_q;
	logic [bmh_pkg::STAT_W-1:0] stat_q;

	logic                      out_valid_q;
	logic signed [KW-1:0]      out_min_q;
	logic [CW-1:0]             out_cnt_q;
	logic [bmh_pkg::STAT_W-1:0] out_stat_q;

	// RAM ports
	logic                      ram_we;
	logic [AW-1:0]             ram_waddr;
	logic [KW-1:0]             ram_wdata;
	logic [AW-1:0]             ram_raddr_a;
	logic [AW-1:0]             ram_raddr_b;
	logic [KW-1:0]             ram_rdata_a;
	logic [KW-1:0]             ram_rdata_b;

	// Tree navigation
	logic [XW-1:0]             left_x;
	logic [XW-1:0]             right_x;
	logic [XW-1:0]             cnt_x;
	logic                      is_leaf;
	logic                      right_ok;
	logic                      pick_right;
	logic signed [KW-1:0]      left_val;
	logic signed [KW-1:0]      right_val;
	logic signed [KW-1:0]      pick_val;
	logic [AW-1:0]             pick_idx;
	logic [AW-1:0]             up_addr;
	logic                      accept;

	assign accept     = s_tvalid && s_tready;
	assign s_tready   = (state_q == ST_IDLE);
	assign m_tvalid   = out_valid_q;
	assign m_tdata    = bmh_pkg::OUT_DATA_W'({out_stat_q, out_cnt_q, out_min_q});

	assign left_x     = {1'b0, pos_q, 1'b1};
	assign right_x    = left_x + XW'(1);
	assign cnt_x      = XW'(cnt_q);
	assign is_leaf    = (left_x >= cnt_x);
	assign right_ok   = (right_x < cnt_x);
	assign left_val   = $signed(ram_rdata_a);
	assign right_val  = $signed(ram_rdata_b);
	assign pick_right = right_ok && (right_val < left_val);
	assign pick_val   = pick_right ? right_val : left_val;
	assign pick_idx   = pick_right ? right_x[AW-1:0] : left_x[AW-1:0];
	assign up_addr    = (pos_q - AW'(1)) >> 1;

	// Read addresses by state
	always_comb begin
		ram_raddr_a = '0;
		ram_raddr_b = '0;
		case (state_q)
			ST_IDLE: begin
				ram_raddr_a = AW'(cnt_q - CW'(1));
			end
			ST_DN_RD: begin
				ram_raddr_a = left_x[AW-1:0];
				ram_raddr_b = right_x[AW-1:0];
			end
			ST_UP_RD: begin
				ram_raddr_a = up_addr;
			end
			default: begin
				ram_raddr_a = '0;
			end
		endcase
	end

	// Write port: move a child/parent into the hole, or drop the key in place
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = key_q;
		case (state_q)
			ST_DN_RD: begin
				ram_we = is_leaf;
			end
			ST_DN_CMP: begin
				ram_we = 1'b1;
				if (pick_val < key_q) begin
					ram_wdata = pick_val;
				end
			end
			ST_UP_RD: begin
				ram_we = (pos_q == '0);
			end
			ST_UP_CMP: begin
				ram_we = 1'b1;
				if (left_val > key_q) begin
					ram_wdata = left_val;
				end
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// Sequencer, shadow root and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			pos_q       <= '0;
			key_q       <= '0;
			root_q      <= '0;
			stat_q      <= bmh_pkg::STAT_OK;
			out_valid_q <= 1'b0;
			out_min_q   <= '0;
			out_cnt_q   <= '0;
			out_stat_q  <= bmh_pkg::STAT_OK;
		end else begin
			// result taken; ST_OUT reloads it itself
			if (out_valid_q && m_tready && (state_q != ST_OUT)) begin
				out_valid_q <= 1'b0;
			end
			if (ram_we && (ram_waddr == '0)) begin
				root_q <= $signed(ram_wdata);
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						key_q  <= $signed(s_tdata);
						if (s_tuser == bmh_pkg::MODE_INSERT) begin
							if (cnt_q >= CW'(bmh_pkg::HEAP_DEPTH)) begin
								stat_q  <= bmh_pkg::STAT_FULL;
								state_q <= ST_OUT;
							end else begin
								stat_q  <= bmh_pkg::STAT_OK;
								pos_q   <= AW'(cnt_q);
								cnt_q   <= cnt_q + CW'(1);
								state_q <= ST_UP_RD;
							end
						end else begin
							if (cnt_q == '0) begin
								stat_q  <= bmh_pkg::STAT_EMPTY;
								state_q <= ST_OUT;
							end else begin
								stat_q  <= bmh_pkg::STAT_OK;
								cnt_q   <= cnt_q - CW'(1);
								state_q <= ST_DEL_LOAD;
							end
						end
					end
				end
				ST_DEL_LOAD: begin
					// last entry becomes the key sifted down from the root
					key_q   <= left_val;
					pos_q   <= '0;
					state_q <= (cnt_q == '0) ? ST_OUT : ST_DN_RD;
				end
				ST_DN_RD: begin
					state_q <= is_leaf ? ST_OUT : ST_DN_CMP;
				end
				ST_DN_CMP: begin
					if (pick_val < key_q) begin
						pos_q   <= pick_idx;
						state_q <= ST_DN_RD;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_UP_RD: begin
					state_q <= (pos_q == '0) ? ST_OUT : ST_UP_CMP;
				end
				ST_UP_CMP: begin
					if (left_val > key_q) begin
						pos_q   <= up_addr;
						state_q <= ST_UP_RD;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						out_min_q   <= (cnt_q == '0) ? '0 : root_q;
						out_cnt_q   <= cnt_q;
						out_stat_q  <= stat_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	bmh_ram #(
		.WIDTH (KW),
		.DEPTH (bmh_pkg::HEAP_DEPTH)
	) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.raddr_a (ram_raddr_a),
		.rdata_a (ram_rdata_a),
		.raddr_b (ram_raddr_b),
		.rdata_b (ram_rdata_b)
	);

endmodule

@@ hw/rtl/bmh_ram.sv @@
// Generic RAM: one write port, two read ports, registered read data.
module bmh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

@@ hw/rtl/bmh_checker.sv @@
// Port-level checks for the heap block.
module bmh_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [bmh_pkg::OUT_DATA_W-1:0] m_tdata
);

	logic [bmh_pkg::KEY_W-1:0]  chk_min;
	logic [bmh_pkg::CNT_W-1:0]  chk_cnt;
	logic [bmh_pkg::STAT_W-1:0] chk_stat;

	assign chk_min  = m_tdata[bmh_pkg::KEY_W-1:0];
	assign chk_cnt  = m_tdata[bmh_pkg::KEY_W +: bmh_pkg::CNT_W];
	assign chk_stat = m_tdata[bmh_pkg::KEY_W + bmh_pkg::CNT_W +: bmh_pkg::STAT_W];

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// only one item in work: input closes right after an accept
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while busy");

	// count never exceeds the heap depth
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> chk_cnt <= bmh_pkg::CNT_W'(bmh_pkg::HEAP_DEPTH))
		else $error("count above depth");

	// empty heap reports a zero minimum
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && chk_cnt == '0 |-> chk_min == '0)
		else $error("nonzero min on empty heap");

	// a rejected delete only happens on an empty heap, a rejected insert on a full one
	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (chk_stat == bmh_pkg::STAT_OK)
			|| (chk_stat == bmh_pkg::STAT_EMPTY && chk_cnt == '0)
			|| (chk_stat == bmh_pkg::STAT_FULL
				&& chk_cnt == bmh_pkg::CNT_W'(bmh_pkg::HEAP_DEPTH)))
		else $error("bad status");

endmodule

bind binary_min_heap bmh_checker u_bmh_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
